[rtl/s8fr_pkg.sv]
// ----------------------------------------------------------------------------
// s8fr_pkg
// Shared constants for the sum-8 frame receiver: frame layout, status codes,
// register indexes and stream widths.
// ----------------------------------------------------------------------------
package s8fr_pkg;

    localparam int unsigned FRAME_LEN   = 15;
    localparam int unsigned COUNT_SAT   = 16;
    localparam int unsigned PAYLOAD_LEN = 12;
    localparam int unsigned CHECK_IDX   = 13;
    localparam int unsigned COUNT_W     = 5;
    localparam int unsigned PIDX_W      = 4;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned STATUS_W    = 2;
    // status + three words = 98 bits, padded to whole bytes
    localparam int unsigned OUT_W       = 104;

    localparam int unsigned CFG_ADDR_W  = 1;

    localparam logic [CFG_ADDR_W-1:0] REG_HEAD = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TAIL = 1'd1;

    localparam logic [BYTE_W-1:0] HEAD_RESET = 8'h5A;
    localparam logic [BYTE_W-1:0] TAIL_RESET = 8'hA5;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_LEN  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_MARK = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_SUM  = 2'd3;

endpackage

[rtl/sum8_frame_receiver.sv]
// ----------------------------------------------------------------------------
// sum8_frame_receiver
// The result is registered: it appears on m_ in the cycle after the tlast beat.
// Throughput: one byte per cycle unless a result waits with m_tready low; the
// byte counter, checksum and payload store all update in the cycle the beat is
// taken, and the result register frees up in the same cycle it is read.
// Reset (aresetn low, synchronous): counter, sum, flags and output valid clear;
// head/tail registers return to 0x5A/0xA5.
// ----------------------------------------------------------------------------
module sum8_frame_receiver (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_wr_en,
    input  logic [s8fr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [s8fr_pkg::BYTE_W-1:0]         cfg_wdata,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [s8fr_pkg::BYTE_W-1:0]         s_tdata,   // [7:0] data_byte
    input  logic                                s_tlast,   // chunk_end

    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [1:0] status, [33:2] word_x, [65:34] word_y, [97:66] word_w, rest zero
    output logic [s8fr_pkg::OUT_W-1:0]          m_tdata
);

    localparam int unsigned BW = s8fr_pkg::BYTE_W;
    localparam int unsigned CW = s8fr_pkg::COUNT_W;

    logic [BW-1:0]  head_reg;
    logic [BW-1:0]  tail_reg;

    logic [CW-1:0]  count_reg, count_next;
    logic [BW-1:0]  sum_reg, sum_next;
    logic           head_ok_reg, head_ok_next;
    logic [BW-1:0]  check_reg, check_next;
    logic [BW-1:0]  payload_reg [s8fr_pkg::PAYLOAD_LEN];

    logic                         out_valid_reg;
    logic [s8fr_pkg::OUT_W-1:0]   out_data_reg, out_data_next;

    logic                          s_beat;
    logic                          is_first;
    logic                          is_payload;
    logic [CW-1:0]                 len;
    logic [s8fr_pkg::STATUS_W-1:0] status;
    logic [s8fr_pkg::WORD_W-1:0]   wx, wy, ww;

    assign s_tready = !out_valid_reg || m_tready;
    assign s_beat   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= s8fr_pkg::HEAD_RESET;
            tail_reg <= s8fr_pkg::TAIL_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                s8fr_pkg::REG_HEAD: head_reg <= cfg_wdata;
                s8fr_pkg::REG_TAIL: tail_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign is_first   = (count_reg == '0);
    assign is_payload = !is_first && (count_reg <= CW'(s8fr_pkg::PAYLOAD_LEN));

    always_comb begin
        sum_next     = sum_reg;
        head_ok_next = head_ok_reg;
        check_next   = check_reg;
        if (is_first) begin
            head_ok_next = (s_tdata == head_reg);
            sum_next     = s_tdata;
        end else if (is_payload) begin
            sum_next = sum_reg + s_tdata;
        end else if (count_reg == CW'(s8fr_pkg::CHECK_IDX)) begin
            check_next = s_tdata;
        end

        // saturating length including this byte
        if (count_reg >= CW'(s8fr_pkg::COUNT_SAT)) begin
            len = CW'(s8fr_pkg::COUNT_SAT);
        end else begin
            len = count_reg + CW'(1);
        end
        count_next = len;

        // sum and check already final when the tail byte is on the input
        if (len != CW'(s8fr_pkg::FRAME_LEN)) begin
            status = s8fr_pkg::ST_BAD_LEN;
        end else if (!head_ok_reg || s_tdata != tail_reg) begin
            status = s8fr_pkg::ST_BAD_MARK;
        end else if (sum_reg != check_reg) begin
            status = s8fr_pkg::ST_BAD_SUM;
        end else begin
            status = s8fr_pkg::ST_OK;
        end

        wx = {payload_reg[3], payload_reg[2], payload_reg[1], payload_reg[0]};
        wy = {payload_reg[7], payload_reg[6], payload_reg[5], payload_reg[4]};
        ww = {payload_reg[11], payload_reg[10], payload_reg[9], payload_reg[8]};
        if (status != s8fr_pkg::ST_OK) begin
            wx = '0;
            wy = '0;
            ww = '0;
        end
        out_data_next = {6'd0, ww, wy, wx, status};

        if (s_tlast) begin
            count_next   = '0;
            sum_next     = '0;
            head_ok_next = 1'b0;
            check_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            sum_reg     <= '0;
            head_ok_reg <= 1'b0;
            check_reg   <= '0;
        end else if (s_beat) begin
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            head_ok_reg <= head_ok_next;
            check_reg   <= check_next;
        end
    end

    // payload bytes 1..12 land in entries 0..11
    always_ff @(posedge aclk) begin
        for (int i = 0; i < s8fr_pkg::PAYLOAD_LEN; i++) begin
            if (s_beat && count_reg == CW'(i + 1)) begin
                payload_reg[i] <= s_tdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_beat && s_tlast) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat && s_tlast) begin
            out_data_reg <= out_data_next;
        end
    end

    // ------------------------------------------------------------------------
    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_beat && s_tlast |=> out_valid_reg)
        else $error("tlast beat did not produce a result");

    a_count_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_beat && s_tlast |=> count_reg == '0)
        else $error("byte counter not cleared after frame end");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(s8fr_pkg::COUNT_SAT))
        else $error("byte counter past saturation");

    a_bad_words_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_data_reg[s8fr_pkg::STATUS_W-1:0] != s8fr_pkg::ST_OK
        |-> out_data_reg[s8fr_pkg::OUT_W-1:s8fr_pkg::STATUS_W] == '0)
        else $error("payload words not zero on a failed frame");

endmodule
